// ----- sv/display_list_clip_quad_emitter_assert.svh -----
// Assertion macros for the display-list clip quad emitter.
// Depends on nothing; included by modules that check their own logic.
`ifndef DISPLAY_LIST_CLIP_QUAD_EMITTER_ASSERT_SVH
`define DISPLAY_LIST_CLIP_QUAD_EMITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define DLCQ_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dlcq assertion failed");
`define DLCQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dlcq assertion failed");
`else
`define DLCQ_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define DLCQ_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- sv/dlcq_pkg.sv -----
// Shared types, operation codes and the clip function of the quad emitter.
// No dependencies.
package dlcq_pkg;

  typedef logic signed [17:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
    logic   ne;
  } frame_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   ok;
  } quad_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  localparam logic [3:0] OP_IGNORE   = 4'd0;
  localparam logic [3:0] OP_RECT     = 4'd1;
  localparam logic [3:0] OP_BORDER   = 4'd2;
  localparam logic [3:0] OP_TEXT     = 4'd3;
  localparam logic [3:0] OP_FOCUS    = 4'd4;
  localparam logic [3:0] OP_IMAGE    = 4'd5;
  localparam logic [3:0] OP_PUSH     = 4'd6;
  localparam logic [3:0] OP_POP      = 4'd7;
  localparam logic [3:0] OP_LIST_END = 4'd8;

  localparam logic [15:0] CAP_RESET = 16'd4096;

  function automatic quad_t clip_quad(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                      logic has_frame, frame_t f);
    quad_t q;
    q.x0 = (has_frame && x0 < f.l) ? f.l : x0;
    q.y0 = (has_frame && y0 < f.t) ? f.t : y0;
    q.x1 = (has_frame && x1 > f.r) ? f.r : x1;
    q.y1 = (has_frame && y1 > f.b) ? f.b : y1;
    q.ok = has_frame ? (f.ne && (q.x0 < q.x1) && (q.y0 < q.y1)) : 1'b1;
    return q;
  endfunction

endpackage

// ----- sv/dlcq_cell.sv -----
// One clip stack cell: holds a frame, shifts down on push and up on pop.
// Depends on dlcq_pkg.
module dlcq_cell (
  input  logic                clk,
  input  dlcq_pkg::stack_ctl_t ctl,
  input  dlcq_pkg::frame_t    above,
  input  dlcq_pkg::frame_t    below,
  output dlcq_pkg::frame_t    frame
);
  import dlcq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      frame <= above;
    end else if (ctl.pop) begin
      frame <= below;
    end
  end
endmodule

// ----- sv/display_list_clip_quad_emitter.sv -----
// Top level of the display-list clip quad emitter.
// Depends on dlcq_pkg, dlcq_cell and the assertion macro header.
//
// One command is held in a single command stage. Each cycle that the output
// register is free, it emits one quad or status, or finishes a command that
// emits nothing. Rect, text, image, clip, ignored and list-end commands emit
// at most one quad or status; border and focus-ring commands emit up to four
// strips one at a time through the single output register. The next command
// is taken in the cycle the current one finishes. The clip stack is a chain of
// CLIP_STACK_DEPTH shift cells with the top frame always in the first cell.
module display_list_clip_quad_emitter #(
  parameter int CLIP_STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          operation,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [15:0]         rect_width,
  input  logic [15:0]         rect_height,
  input  logic [15:0]         border_thickness,
  input  logic [31:0]         fill_color,
  input  logic [31:0]         img_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_status,
  output logic signed [17:0]  quad_x0,
  output logic signed [17:0]  quad_y0,
  output logic signed [17:0]  quad_x1,
  output logic signed [17:0]  quad_y1,
  output logic [31:0]         quad_color,
  output logic [31:0]         quad_tex,
  output logic [15:0]         uv_width,
  output logic [15:0]         uv_height,
  output logic [15:0]         quad_index,
  output logic                error,
  output logic                last
);
  import dlcq_pkg::*;

  localparam int DW = $clog2(CLIP_STACK_DEPTH + 1);

  logic              sv;
  logic [3:0]        op;
  logic signed [15:0] cx, cy;
  logic [15:0]       cw, ch, cbw;
  logic [31:0]       ccol, cimg;
  logic [3:0]        rem;
  logic [DW-1:0]     depth;
  logic [15:0]       count;
  logic              err;
  logic [15:0]       cap;

  frame_t            frames [CLIP_STACK_DEPTH];
  frame_t            new_frame;
  stack_ctl_t        ctl;

  coord_t            xs, ys, ws, hs, bws;
  logic [15:0]       bwc, ih, swd;
  logic              inner;
  coord_t            sx [4];
  coord_t            sy [4];
  logic [15:0]       sw [4];
  logic [15:0]       sh [4];
  logic [3:0]        en;
  logic [3:0]        surv;
  quad_t             q [4];
  quad_t             pq;
  logic [3:0]        cand, first;
  logic              later;
  quad_t             selq;
  logic              has_frame;
  logic              adv, fin, done, emit, emit_status;
  logic              is_single, is_border;
  logic [16:0]       count_inc;

  assign has_frame = (depth != '0);
  assign xs  = {{2{cx[15]}}, cx};
  assign ys  = {{2{cy[15]}}, cy};
  assign ws  = {2'b00, cw};
  assign hs  = {2'b00, ch};
  assign bwc = (cbw > ch) ? ch : cbw;
  assign bws = {2'b00, bwc};
  assign inner = {1'b0, ch} > {bwc, 1'b0};
  assign ih  = ch - {bwc[14:0], 1'b0};
  assign swd = (cw < bwc) ? cw : bwc;

  assign is_single = (op == OP_RECT) || (op == OP_TEXT) || (op == OP_IMAGE);
  assign is_border = (op == OP_BORDER) || (op == OP_FOCUS);

  always_comb begin
    sx[0] = xs;  sy[0] = ys;  sw[0] = cw;  sh[0] = ch;
    sx[1] = xs;  sy[1] = ys + hs - bws;  sw[1] = cw;  sh[1] = bwc;
    sx[2] = xs;  sy[2] = ys + bws;  sw[2] = swd;  sh[2] = ih;
    sx[3] = xs + ws - bws;  sy[3] = ys + bws;  sw[3] = swd;  sh[3] = ih;
    en = 4'b0000;
    if (is_single) begin
      en[0] = 1'b1;
    end else if (is_border) begin
      sh[0] = bwc;
      en[0] = (bwc != 16'd0);
      en[1] = (bwc != 16'd0);
      en[2] = (bwc != 16'd0) && inner;
      en[3] = (bwc != 16'd0) && inner && (cw > bwc);
    end
    for (int k = 0; k < 4; k++) begin
      q[k] = clip_quad(sx[k], sy[k], sx[k] + $signed({2'b00, sw[k]}),
                       sy[k] + $signed({2'b00, sh[k]}), has_frame, frames[0]);
      surv[k] = en[k] && (sw[k] != 16'd0) && (sh[k] != 16'd0) && q[k].ok;
    end
  end

  assign cand  = surv & rem;
  assign first = cand & (~cand + 4'd1);
  assign later = |(cand & ~first);

  always_comb begin
    selq = q[0];
    for (int k = 3; k >= 0; k--) begin
      if (first[k]) begin
        selq = q[k];
      end
    end
  end

  assign pq = clip_quad(xs, ys, xs + ws, ys + hs, has_frame, frames[0]);
  always_comb begin
    new_frame.l  = pq.x0;
    new_frame.t  = pq.y0;
    new_frame.r  = pq.x1;
    new_frame.b  = pq.y1;
    new_frame.ne = pq.ok && (cw != 16'd0) && (ch != 16'd0);
  end

  assign count_inc = {1'b0, count} + 17'd1;
  assign adv = !out_valid || !out_stall;

  always_comb begin
    fin         = 1'b1;
    emit        = 1'b0;
    emit_status = 1'b0;
    ctl         = '0;
    if (op == OP_LIST_END) begin
      emit_status = 1'b1;
    end else if (!err) begin
      if (is_single || is_border) begin
        if (cand != 4'b0000 && count < cap) begin
          emit = 1'b1;
          fin  = !later || (count_inc >= {1'b0, cap});
        end
      end else if (op == OP_PUSH) begin
        ctl.push = (depth < DW'(CLIP_STACK_DEPTH));
      end else if (op == OP_POP) begin
        ctl.pop = has_frame;
      end
    end
    if (!(sv && adv)) begin
      emit        = 1'b0;
      emit_status = 1'b0;
      ctl         = '0;
    end
  end

  assign done     = sv && adv && fin;
  assign in_stall = sv && !done;

  for (genvar i = 0; i < CLIP_STACK_DEPTH; i++) begin : g_cell
    frame_t above, below;
    assign above = (i == 0) ? new_frame : frames[(i == 0) ? 0 : i - 1];
    assign below = (i == CLIP_STACK_DEPTH - 1) ? frames[i]
                   : frames[(i == CLIP_STACK_DEPTH - 1) ? i : i + 1];
    dlcq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .frame (frames[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv    <= 1'b0;
      depth <= '0;
      count <= 16'd0;
      err   <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sv <= 1'b1;
      end else if (done) begin
        sv <= 1'b0;
      end
      if (emit_status) begin
        depth <= '0;
        count <= 16'd0;
        err   <= 1'b0;
      end else if (sv && adv && !err) begin
        if (emit) begin
          count <= count_inc[15:0];
          if (later && (count_inc >= {1'b0, cap})) begin
            err <= 1'b1;
          end
        end else if ((is_single || is_border) && cand != 4'b0000) begin
          err <= 1'b1;
        end else if (op == OP_PUSH) begin
          if (ctl.push) begin
            depth <= depth + DW'(1);
          end else begin
            err <= 1'b1;
          end
        end else if (op == OP_POP) begin
          if (ctl.pop) begin
            depth <= depth - DW'(1);
          end else begin
            err <= 1'b1;
          end
        end else if (op > OP_LIST_END) begin
          err <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op   <= operation;
      cx   <= pos_x;
      cy   <= pos_y;
      cw   <= rect_width;
      ch   <= rect_height;
      cbw  <= border_thickness;
      ccol <= fill_color;
      cimg <= img_handle;
      rem  <= 4'b1111;
    end else if (emit) begin
      rem <= rem & ~first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || emit_status) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_status) begin
      is_status  <= 1'b1;
      quad_x0    <= '0;
      quad_y0    <= '0;
      quad_x1    <= '0;
      quad_y1    <= '0;
      quad_color <= 32'd0;
      quad_tex   <= 32'd0;
      uv_width   <= 16'd0;
      uv_height  <= 16'd0;
      quad_index <= count;
      error      <= err || has_frame;
      last       <= 1'b1;
    end else if (emit) begin
      is_status  <= 1'b0;
      quad_x0    <= selq.x0;
      quad_y0    <= selq.y0;
      quad_x1    <= selq.x1;
      quad_y1    <= selq.y1;
      quad_color <= ccol;
      quad_tex   <= (op == OP_IMAGE) ? cimg : 32'd0;
      uv_width   <= (op == OP_IMAGE) ? cw : 16'd0;
      uv_height  <= (op == OP_IMAGE) ? ch : 16'd0;
      quad_index <= count;
      error      <= 1'b0;
      last       <= fin;
    end
  end

`include "display_list_clip_quad_emitter_assert.svh"

  `DLCQ_ASSERT_NOW(a_no_overwrite, clk, rst, out_valid && out_stall, !emit && !emit_status)
  `DLCQ_ASSERT_NOW(a_depth_bound, clk, rst, 1'b1, depth <= DW'(CLIP_STACK_DEPTH))
  `DLCQ_ASSERT_NEXT(a_list_end_clears, clk, rst, emit_status, depth == '0 && count == 16'd0 && !err)

endmodule
